>>> rtl/core/sms_pkg.sv
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants for the square matrix symmetrizer core.
// ----------------------------------------------------------------------------
`default_nettype none

package sms_pkg;

   localparam int MAX_DIM    = 64;
   localparam int IDX_W      = $clog2(MAX_DIM);
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int CNT_W      = 7;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;

   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_DIM);
   localparam logic [CNT_W-1:0] DIM_LIMIT   = CNT_W'(MAX_DIM);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE      = 2'd0,
      CMD_READ       = 2'd1,
      CMD_SYMMETRIZE = 2'd2,
      CMD_NONE       = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_RANGE      = 2'd1,
      STATUS_NOT_SQUARE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE         = 2'd0,
      CSR_ROW_COUNT    = 2'd1,
      CSR_COLUMN_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SYM_RD_UP,
      ST_SYM_RD_LO,
      ST_SYM_WR_UP,
      ST_SYM_WR_LO
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/square_matrix_symmetrizer_core.sv
// ----------------------------------------------------------------------------
// square_matrix_symmetrizer_core
// Element store for a signed 2D spectrum with write, read and symmetrize.
//
// Requests enter on req_* when start is high and busy is low. Each request
// gives exactly one response on rsp_*, shown for one cycle with rsp_valid;
// the receiver cannot hold it off.
// Write: stored at the accepting edge, response in the next cycle, busy stays
//   low, so a request can follow in every cycle.
// Read: one store read port with registered data; the data passes rd_data_ff
//   then state ST_READ into the rsp_* registers, busy high for one cycle.
// Symmetrize: the single pair unit works one mirrored pair at a time
//   (read upper, read lower, write upper, write lower) over the store's read
//   and write ports, covering n*(n-1)/2 pairs before the response.
// The user writes csr_* (index 0 mode, 1 row count, 2 column count) only while
//   idle; not checked by the core. Reset clears control state and registers;
//   the store is not cleared and an element must be written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module square_matrix_symmetrizer_core
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [sms_pkg::CMD_W-1:0]      req_command,
   input  wire logic [sms_pkg::IDX_W-1:0]      req_row,
   input  wire logic [sms_pkg::IDX_W-1:0]      req_col,
   input  wire logic signed [sms_pkg::DATA_W-1:0] req_value,
   output logic                                rsp_valid,
   output logic signed [sms_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [sms_pkg::STATUS_W-1:0]        rsp_status,
   input  wire logic                           csr_write_enable,
   input  wire logic [sms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sms_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import sms_pkg::*;

   state_type state_ff, state_in;

   logic             mode_ff;
   logic [CNT_W-1:0] row_count_ff;
   logic [CNT_W-1:0] column_count_ff;

   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] n_ff, n_in;

   logic signed [DATA_W-1:0] a_ff, a_in;
   logic signed [DATA_W-1:0] r_ff, r_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   logic [CNT_W-1:0]         n_row;
   logic [CNT_W-1:0]         n_col;
   logic                     in_range;
   logic                     accept;
   cmd_type                  cmd;
   logic signed [DATA_W-1:0] sat_value;

   logic signed [DATA_W-1:0] pair_r;
   logic signed [DATA_W-1:0] half_a;
   logic signed [DATA_W-1:0] half_b;
   logic [DATA_W-1:0]        mag_a;
   logic [DATA_W-1:0]        mag_b;
   logic                     j_last;
   logic                     i_last;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= 1'b0;
         row_count_ff    <= COUNT_RESET;
         column_count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE:         mode_ff         <= csr_write_data[0];
            CSR_ROW_COUNT:    row_count_ff    <= csr_write_data[CNT_W-1:0];
            CSR_COLUMN_COUNT: column_count_ff <= csr_write_data[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // element store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // pair unit
   always_comb begin
      half_a = $signed(a_ff + DATA_W'($unsigned(a_ff[DATA_W-1]))) >>> 1;
      half_b = $signed(rd_data_ff + DATA_W'($unsigned(rd_data_ff[DATA_W-1]))) >>> 1;
      mag_a  = a_ff[DATA_W-1] ? DATA_W'(-a_ff) : DATA_W'(a_ff);
      mag_b  = rd_data_ff[DATA_W-1] ? DATA_W'(-rd_data_ff) : DATA_W'(rd_data_ff);
      priority if (!mode_ff) begin
         pair_r = half_a + half_b;
      end else if ((a_ff >= 0 && rd_data_ff <= 0) || (a_ff <= 0 && rd_data_ff >= 0)) begin
         pair_r = '0;
      end else if (mag_a <= mag_b) begin
         pair_r = a_ff;
      end else begin
         pair_r = rd_data_ff;
      end
   end

   assign n_row     = (row_count_ff > DIM_LIMIT) ? DIM_LIMIT : row_count_ff;
   assign n_col     = (column_count_ff > DIM_LIMIT) ? DIM_LIMIT : column_count_ff;
   assign in_range  = (CNT_W'(req_row) < n_row) && (CNT_W'(req_col) < n_col);
   assign accept    = start && (state_ff == ST_IDLE);
   assign cmd       = cmd_type'(req_command);
   assign sat_value = (req_value == {1'b1, {(DATA_W-1){1'b0}}}) ?
                      {1'b1, {(DATA_W-2){1'b0}}, 1'b1} : req_value;
   assign j_last    = (CNT_W'(j_ff) + CNT_W'(1)) == n_ff;
   assign i_last    = (CNT_W'(i_ff) + CNT_W'(2)) >= n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      n_ff          <= n_in;
      a_ff          <= a_in;
      r_ff          <= r_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      a_in          = a_ff;
      r_in          = r_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = {req_row, req_col};
      wr_en         = 1'b0;
      wr_addr       = {req_row, req_col};
      wr_data       = sat_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_value_in  = '0;
               rsp_status_in = STATUS_OK;
               unique case (cmd)
                  CMD_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (in_range) begin
                        wr_en = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_RANGE;
                     end
                  end
                  CMD_READ: begin
                     if (in_range) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                     end
                  end
                  CMD_SYMMETRIZE: begin
                     i_in = '0;
                     j_in = IDX_W'(1);
                     n_in = n_row;
                     if (row_count_ff != column_count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NOT_SQUARE;
                     end else if (n_row <= CNT_W'(1)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_SYM_RD_UP;
                     end
                  end
                  CMD_NONE: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = rd_data_ff;
            rsp_status_in = STATUS_OK;
            state_in      = ST_IDLE;
         end
         ST_SYM_RD_UP: begin
            rd_addr  = {i_ff, j_ff};
            state_in = ST_SYM_RD_LO;
         end
         ST_SYM_RD_LO: begin
            rd_addr  = {j_ff, i_ff};
            a_in     = rd_data_ff;
            state_in = ST_SYM_WR_UP;
         end
         ST_SYM_WR_UP: begin
            wr_en    = 1'b1;
            wr_addr  = {i_ff, j_ff};
            wr_data  = pair_r;
            r_in     = pair_r;
            state_in = ST_SYM_WR_LO;
         end
         ST_SYM_WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = {j_ff, i_ff};
            wr_data = r_ff;
            if (!j_last) begin
               j_in     = j_ff + IDX_W'(1);
               state_in = ST_SYM_RD_UP;
            end else if (!i_last) begin
               i_in     = i_ff + IDX_W'(1);
               j_in     = i_ff + IDX_W'(2);
               state_in = ST_SYM_RD_UP;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

>>> test/square_matrix_symmetrizer_checker.sv
// ----------------------------------------------------------------------------
// square_matrix_symmetrizer_checker
// Watches the request, response and register ports of the symmetrizer core.
// Keeps its own copy of the element store and registers, works out the
// response of every accepted request and compares each response in order.
// ----------------------------------------------------------------------------
`default_nettype none

module square_matrix_symmetrizer_checker
(
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              busy,
   input  wire logic [sms_pkg::CMD_W-1:0]         req_command,
   input  wire logic [sms_pkg::IDX_W-1:0]         req_row,
   input  wire logic [sms_pkg::IDX_W-1:0]         req_col,
   input  wire logic signed [sms_pkg::DATA_W-1:0] req_value,
   input  wire logic                              rsp_valid,
   input  wire logic signed [sms_pkg::DATA_W-1:0] rsp_read_value,
   input  wire logic [sms_pkg::STATUS_W-1:0]      rsp_status,
   input  wire logic                              csr_write_enable,
   input  wire logic [sms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sms_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output int                                     error_count,
   output int                                     pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import sms_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      status_type               status;
   } response_type;

   response_type             expected_responses[$];
   logic signed [DATA_W-1:0] element [MAX_DIM][MAX_DIM];
   logic                     lowest_mode;
   logic [CNT_W-1:0]         rows_reg;
   logic [CNT_W-1:0]         cols_reg;
   int                       mismatches = 0;

   function automatic int dim_in_use(logic [CNT_W-1:0] n);
      return (n > DIM_LIMIT) ? MAX_DIM : int'(n);
   endfunction

   function automatic logic signed [DATA_W-1:0] magnitude(logic signed [DATA_W-1:0] v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic signed [DATA_W-1:0] merge_pair(logic signed [DATA_W-1:0] upper,
                                                           logic signed [DATA_W-1:0] lower);
      if (!lowest_mode) begin
         return upper / 2 + lower / 2;
      end else if ((upper >= 0 && lower <= 0) || (upper <= 0 && lower >= 0)) begin
         return '0;
      end else if (magnitude(upper) <= magnitude(lower)) begin
         return upper;
      end else begin
         return lower;
      end
   endfunction

   function automatic response_type predict_response(cmd_type cmd, logic [IDX_W-1:0] row,
                                                     logic [IDX_W-1:0] col,
                                                     logic signed [DATA_W-1:0] value);
      response_type             r;
      logic signed [DATA_W-1:0] merged;
      int                       n;
      r.read_value = '0;
      r.status     = STATUS_OK;
      case (cmd)
         CMD_WRITE, CMD_READ: begin
            if (row >= dim_in_use(rows_reg) || col >= dim_in_use(cols_reg)) begin
               r.status = STATUS_RANGE;
            end else if (cmd == CMD_WRITE) begin
               element[row][col] = (value == 32'sh80000000) ? 32'sh80000001 : value;
            end else begin
               r.read_value = element[row][col];
            end
         end
         CMD_SYMMETRIZE: begin
            if (rows_reg != cols_reg) begin
               r.status = STATUS_NOT_SQUARE;
            end else begin
               n = dim_in_use(rows_reg);
               for (int i = 0; i < n; i++) begin
                  for (int j = i + 1; j < n; j++) begin
                     merged        = merge_pair(element[i][j], element[j][i]);
                     element[i][j] = merged;
                     element[j][i] = merged;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         lowest_mode = 1'b0;
         rows_reg    = COUNT_RESET;
         cols_reg    = COUNT_RESET;
         expected_responses.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_responses.size() == 0) begin
               mismatches++;
               $error("response with no request outstanding: read_value %0d status %0d",
                      rsp_read_value, rsp_status);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  mismatches++;
                  $error("read_value mismatch: expected %0d, got %0d",
                         want.read_value, rsp_read_value);
               end
               if (rsp_status !== want.status) begin
                  mismatches++;
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_MODE:         lowest_mode = csr_write_data[0];
               CSR_ROW_COUNT:    rows_reg    = csr_write_data;
               CSR_COLUMN_COUNT: cols_reg    = csr_write_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_responses.push_back(predict_response(cmd_type'(req_command), req_row,
                                                          req_col, req_value));
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_responses.size();
   end

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the square matrix symmetrizer core.
// A directed run covers saturation, both symmetrize rules, the not-square and
// out-of-range answers and the unused command; random phases then sweep many
// register settings with element writes, reads and symmetrize passes, with
// random gaps between requests. Symmetrize is only issued once every mirrored
// element in use has been written. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import sms_pkg::*;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int PHASE_ITEMS    = 45;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     start            = 1'b0;
   logic                     busy;
   logic [CMD_W-1:0]         req_command      = CMD_WRITE;
   logic [IDX_W-1:0]         req_row          = '0;
   logic [IDX_W-1:0]         req_col          = '0;
   logic signed [DATA_W-1:0] req_value        = '0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index        = CSR_MODE;
   logic [CSR_DATA_W-1:0]    csr_write_data   = '0;
   int                       error_count;
   int                       pending_count;

   bit written [MAX_DIM][MAX_DIM];
   int raw_rows = MAX_DIM;
   int raw_cols = MAX_DIM;
   int dim_rows = MAX_DIM;
   int dim_cols = MAX_DIM;
   int request_count = 0;
   int symmetrize_count = 0;
   int setting_count = 0;
   int idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   square_matrix_symmetrizer_core uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   square_matrix_symmetrizer_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic issue_request(cmd_type cmd, int row, int col, logic signed [DATA_W-1:0] value);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_row     <= IDX_W'(row);
      req_col     <= IDX_W'(col);
      req_value   <= value;
      do @(posedge clock); while (busy);
      if (cmd == CMD_WRITE && row < dim_rows && col < dim_cols) begin
         written[row][col] = 1'b1;
      end
      if (cmd == CMD_SYMMETRIZE) begin
         symmetrize_count++;
      end
      request_count++;
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
   endtask

   task automatic set_config(logic lowest, int rows, int cols);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MODE;
      csr_write_data   <= CSR_DATA_W'(lowest);
      @(posedge clock);
      csr_index        <= CSR_ROW_COUNT;
      csr_write_data   <= CSR_DATA_W'(rows);
      @(posedge clock);
      csr_index        <= CSR_COLUMN_COUNT;
      csr_write_data   <= CSR_DATA_W'(cols);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      raw_rows = rows;
      raw_cols = cols;
      dim_rows = (rows > MAX_DIM) ? MAX_DIM : rows;
      dim_cols = (cols > MAX_DIM) ? MAX_DIM : cols;
      setting_count++;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0:       return 32'sh80000000;
               1:       return 32'sh80000001;
               2:       return 32'sh7fffffff;
               3:       return 32'sh0;
               4:       return 32'sh1;
               default: return -32'sh1;
            endcase
         end
         1, 2, 3: return int'($urandom_range(0, 8)) - 4;
         default: return $urandom();
      endcase
   endfunction

   task automatic issue_out_of_range();
      int row;
      int col;
      cmd_type cmd;
      cmd = ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ;
      row = $urandom_range(0, MAX_DIM - 1);
      col = $urandom_range(0, MAX_DIM - 1);
      if (dim_rows < MAX_DIM && (dim_cols == MAX_DIM || $urandom_range(0, 1) == 0)) begin
         row = $urandom_range(dim_rows, MAX_DIM - 1);
      end else begin
         col = $urandom_range(dim_cols, MAX_DIM - 1);
      end
      issue_request(cmd, row, col, pick_value());
   endtask

   task automatic issue_in_range(bit want_read);
      int row;
      int col;
      if (dim_rows == 0 || dim_cols == 0) begin
         issue_out_of_range();
      end else begin
         row = $urandom_range(0, dim_rows - 1);
         col = $urandom_range(0, dim_cols - 1);
         if (want_read && written[row][col]) begin
            issue_request(CMD_READ, row, col, pick_value());
         end else begin
            issue_request(CMD_WRITE, row, col, pick_value());
         end
      end
   endtask

   task automatic run_symmetrize();
      int n;
      int i;
      int j;
      n = dim_rows;
      if (raw_rows == raw_cols) begin
         for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               if (r != c && !written[r][c]) begin
                  issue_request(CMD_WRITE, r, c, pick_value());
               end
            end
         end
      end
      issue_request(CMD_SYMMETRIZE, $urandom_range(0, MAX_DIM - 1),
                    $urandom_range(0, MAX_DIM - 1), $urandom());
      if (raw_rows == raw_cols && n >= 2) begin
         repeat (4) begin
            i = $urandom_range(0, n - 2);
            j = $urandom_range(i + 1, n - 1);
            issue_request(CMD_READ, i, j, $urandom());
            issue_request(CMD_READ, j, i, $urandom());
         end
      end
   endtask

   task automatic run_phase(int items);
      int pick;
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            issue_in_range(1'b0);
         end else if (pick < 75) begin
            issue_in_range(1'b1);
         end else if (pick < 87) begin
            if (dim_rows < MAX_DIM || dim_cols < MAX_DIM) begin
               issue_out_of_range();
            end else begin
               issue_in_range(1'b1);
            end
         end else if (pick < 93) begin
            issue_request(CMD_NONE, $urandom_range(0, MAX_DIM - 1),
                          $urandom_range(0, MAX_DIM - 1), $urandom());
         end else if (dim_rows > 16 && raw_rows == raw_cols) begin
            issue_in_range(1'b1);
         end else begin
            run_symmetrize();
         end
      end
   endtask

   initial begin
      int fixed_settings [11][3] = '{
         '{0, 4, 4}, '{1, 4, 4}, '{1, 1, 1}, '{0, 127, 127}, '{1, 64, 64}, '{0, 0, 0},
         '{1, 64, 127}, '{0, 3, 9}, '{1, 100, 100}, '{0, 2, 2}, '{1, 7, 7}
      };
      int n;
      int m;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values, saturation and corners
      issue_request(CMD_WRITE, 0, 0, 32'sh80000000);
      issue_request(CMD_READ, 0, 0, 32'sh0);
      issue_request(CMD_WRITE, 63, 63, 32'sh7fffffff);
      issue_request(CMD_READ, 63, 63, 32'sh0);
      issue_request(CMD_WRITE, 63, 0, -32'sh1);
      issue_request(CMD_READ, 63, 0, 32'sh0);
      issue_request(CMD_NONE, 63, 63, 32'sh7fffffff);

      // lowest magnitude, same sign then differing signs
      set_config(1'b1, 2, 2);
      issue_request(CMD_WRITE, 0, 1, -32'sh7);
      issue_request(CMD_WRITE, 1, 0, -32'sh3);
      issue_request(CMD_SYMMETRIZE, 0, 0, 32'sh0);
      issue_request(CMD_READ, 0, 1, 32'sh0);
      issue_request(CMD_READ, 1, 0, 32'sh0);
      issue_request(CMD_WRITE, 0, 1, 32'sh5);
      issue_request(CMD_WRITE, 1, 0, -32'sh5);
      issue_request(CMD_SYMMETRIZE, 0, 0, 32'sh0);
      issue_request(CMD_READ, 0, 1, 32'sh0);

      // average with truncation toward zero
      set_config(1'b0, 2, 2);
      issue_request(CMD_WRITE, 0, 1, 32'sh7);
      issue_request(CMD_WRITE, 1, 0, 32'sh80000001);
      issue_request(CMD_SYMMETRIZE, 0, 0, 32'sh0);
      issue_request(CMD_READ, 1, 0, 32'sh0);

      // not square and index outside size
      set_config(1'b0, 3, 2);
      issue_request(CMD_SYMMETRIZE, 0, 0, 32'sh0);
      issue_request(CMD_WRITE, 2, 1, 32'sh11);
      issue_request(CMD_READ, 0, 2, 32'sh0);

      // zero counts
      set_config(1'b1, 0, 0);
      issue_request(CMD_WRITE, 0, 0, 32'sh1);
      issue_request(CMD_SYMMETRIZE, 0, 0, 32'sh0);

      for (int k = 0; k < 11; k++) begin
         set_config(fixed_settings[k][0][0], fixed_settings[k][1], fixed_settings[k][2]);
         run_phase(PHASE_ITEMS);
      end

      repeat (5) begin
         n = $urandom_range(1, 8);
         if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(65, 127);
         end
         m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : n;
         set_config($urandom_range(0, 1), n, m);
         run_phase(PHASE_ITEMS);
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      $display("covered %0d requests, %0d of them symmetrize, over %0d register settings",
               request_count, symmetrize_count, setting_count);
      $display("both rules, counts from zero to 127, square and non-square shapes");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
